### sv/sprite_depth_sort_top_assert.svh
// Assertion macros for the depth sort block
`ifndef SPRITE_DEPTH_SORT_TOP_ASSERT_SVH
`define SPRITE_DEPTH_SORT_TOP_ASSERT_SVH

// antecedent implies consequent in the next cycle
`define SDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define SDS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

### sv/sds_pkg.sv
package sds_pkg;

    localparam int MaxObjects = 64;
    localparam int AddrW      = $clog2(MaxObjects);
    localparam int CountW     = $clog2(MaxObjects + 1);
    localparam int CoordW     = 24;
    localparam int KeyW       = 24;
    localparam int TagW       = 7;
    localparam int SqW        = 50;   // dx^2 + dy^2, dx,dy up to 25 bits
    localparam int RootW      = 25;
    localparam int DivW       = 28;   // 10 << 24 fits in 28 bits
    localparam logic [DivW-1:0] TenScaled = DivW'(10) << 24;
    localparam logic [KeyW-1:0] KeyMax = '1;

    localparam logic [0:0] RegViewerX = 1'b0;
    localparam logic [0:0] RegViewerY = 1'b1;

    typedef struct packed {
        logic signed [CoordW-1:0] pos_x;
        logic signed [CoordW-1:0] pos_y;
        logic                     obj_kind;
        logic [5:0]               obj_index;
        logic                     last_load;
    } in_item_t;

    typedef struct packed {
        logic [KeyW-1:0] inv_distance;
        logic            out_kind;
        logic [5:0]      out_index;
        logic            last_out;
    } out_item_t;

    typedef struct packed {
        logic                     reg_index;
        logic [CoordW-1:0]        data;
    } cfg_item_t;

endpackage

### sv/sds_if.sv
interface sds_in_if;
    logic               valid;
    logic               ready;
    sds_pkg::in_item_t  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sds_out_if;
    logic               valid;
    logic               ready;
    sds_pkg::out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface sds_cfg_if;
    logic               valid;
    logic               ready;
    logic [31:0]        reg_index;
    logic [23:0]        data;
    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

### sv/sprite_depth_sort_top.sv
// Channel   Dir  Payload
// in_ch     in   pos_x, pos_y, obj_kind, obj_index, last_load
// out_ch    out  inv_distance, out_kind, out_index, last_out
// cfg_ch    in   reg_index, data (viewer_x = 0, viewer_y = 1)
// A new load is taken only after the last one is through: 2 squares, 25 root steps,
// 28 divide steps, 1 store write and a return to idle.
// On last_load, an insertion sort walks the key memory, each compare through a read
// state and a compare state, then emits the entries, each through a read and an emit state.
// Reset (rst_n, async low) clears the state, count, viewer and output valid registers only.
// Stalls on out_ch hold the emit address; in_ch is ready only when idle.
module sprite_depth_sort_top (
    input logic       clk,
    input logic       rst_n,
    sds_in_if.sink    in_ch,
    sds_out_if.source out_ch,
    sds_cfg_if.sink   cfg_ch
);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_ROOT, S_DIV, S_WRITE,
        S_SORT_RD, S_SORT_CMP, S_SORT_PUT, S_EMIT_RD, S_EMIT
    } state_t;

    state_t state_reg;

    // memories: key and tag, one read port, one write port each
    logic [sds_pkg::KeyW-1:0] key_mem [sds_pkg::MaxObjects];
    logic [sds_pkg::TagW-1:0] tag_mem [sds_pkg::MaxObjects];
    logic [sds_pkg::KeyW-1:0] key_rd_reg;
    logic [sds_pkg::TagW-1:0] tag_rd_reg;
    logic [sds_pkg::AddrW-1:0] rd_addr;
    logic [sds_pkg::AddrW-1:0] wr_addr;
    logic                      wr_en;
    logic [sds_pkg::KeyW-1:0]  wr_key;
    logic [sds_pkg::TagW-1:0]  wr_tag;

    logic signed [sds_pkg::CoordW-1:0] viewer_x_reg, viewer_y_reg;
    logic [sds_pkg::CountW-1:0] count_reg;
    logic                       last_reg;
    logic [sds_pkg::TagW-1:0]   tag_reg;

    // arithmetic state
    logic [sds_pkg::RootW-1:0] ax_reg, ay_reg;
    logic [sds_pkg::SqW-1:0]   rem_reg;        // sqrt remainder
    logic [sds_pkg::SqW-1:0]   sqin_reg;       // radicand being consumed
    logic [sds_pkg::RootW-1:0] root_reg;
    logic [sds_pkg::DivW-1:0]  dnum_reg;
    logic [sds_pkg::RootW:0]   drem_reg;
    logic [sds_pkg::DivW-1:0]  quot_reg;
    logic [5:0]                step_reg;
    logic                      sqphase_reg;
    logic [sds_pkg::KeyW-1:0]  key_reg;

    // sort state
    logic [sds_pkg::CountW-1:0] i_reg, j_reg;
    logic [sds_pkg::KeyW-1:0]   skey_reg;
    logic [sds_pkg::TagW-1:0]   stag_reg;
    logic [sds_pkg::CountW-1:0] e_reg;

    logic                       out_valid_reg;
    sds_pkg::out_item_t         out_reg;

    logic signed [sds_pkg::RootW-1:0] dx, dy;
    logic [sds_pkg::SqW-1:0]   sq_trial;
    logic [sds_pkg::SqW-1:0]   sq_rem_sh;
    logic [sds_pkg::RootW:0]   div_sh;
    logic [2*sds_pkg::RootW-1:0] sq_prod;
    logic [sds_pkg::RootW-1:0] sq_op;

    // input and config handshake
    assign in_ch.ready  = (state_reg == S_IDLE);
    assign cfg_ch.ready = 1'b1;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    always_comb
    begin
        dx = sds_pkg::RootW'(viewer_x_reg) - sds_pkg::RootW'(in_ch.data.pos_x);
        dy = sds_pkg::RootW'(viewer_y_reg) - sds_pkg::RootW'(in_ch.data.pos_y);
        // one square per cycle, operand chosen by phase
        sq_op     = sqphase_reg ? ay_reg : ax_reg;
        sq_prod   = sq_op * sq_op;
        // sqrt step: two radicand bits per cycle
        sq_rem_sh = {rem_reg[sds_pkg::SqW-3:0], sqin_reg[sds_pkg::SqW-1 -: 2]};
        sq_trial  = sds_pkg::SqW'({root_reg, 2'b01});
        // divider step
        div_sh    = {drem_reg[sds_pkg::RootW-1:0], dnum_reg[sds_pkg::DivW-1]};
    end

    // memory access
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            key_mem[wr_addr] <= wr_key;
            tag_mem[wr_addr] <= wr_tag;
        end
        key_rd_reg <= key_mem[rd_addr];
        tag_rd_reg <= tag_mem[rd_addr];
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = count_reg[sds_pkg::AddrW-1:0];
        wr_key  = key_reg;
        wr_tag  = tag_reg;
        rd_addr = e_reg[sds_pkg::AddrW-1:0];
        case (state_reg)
            S_WRITE:
            begin
                wr_en = (count_reg < sds_pkg::CountW'(sds_pkg::MaxObjects));
            end
            S_SORT_RD:
            begin
                rd_addr = (j_reg == '0) ? i_reg[sds_pkg::AddrW-1:0]
                                        : sds_pkg::AddrW'(j_reg - 1'b1);
            end
            S_SORT_CMP:
            begin
                // shift the larger neighbor up
                wr_en   = (j_reg != '0) && (key_rd_reg > skey_reg);
                wr_addr = j_reg[sds_pkg::AddrW-1:0];
                wr_key  = key_rd_reg;
                wr_tag  = tag_rd_reg;
            end
            S_SORT_PUT:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg[sds_pkg::AddrW-1:0];
                wr_key  = skey_reg;
                wr_tag  = stag_reg;
            end
            default: ;
        endcase
    end

    // control and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            viewer_x_reg  <= '0;
            viewer_y_reg  <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                if (cfg_ch.reg_index == 32'(sds_pkg::RegViewerX))
                    viewer_x_reg <= cfg_ch.data;
                else if (cfg_ch.reg_index == 32'(sds_pkg::RegViewerY))
                    viewer_y_reg <= cfg_ch.data;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_ch.valid)
                    begin
                        ax_reg      <= dx[sds_pkg::RootW-1] ? -dx : dx;
                        ay_reg      <= dy[sds_pkg::RootW-1] ? -dy : dy;
                        tag_reg     <= {in_ch.data.obj_kind, in_ch.data.obj_index};
                        last_reg    <= in_ch.data.last_load;
                        sqphase_reg <= 1'b0;
                        sqin_reg    <= '0;
                        state_reg   <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    sqin_reg    <= sqin_reg + sds_pkg::SqW'(sq_prod);
                    sqphase_reg <= 1'b1;
                    if (sqphase_reg)
                    begin
                        rem_reg   <= '0;
                        root_reg  <= '0;
                        step_reg  <= 6'(sds_pkg::RootW);
                        state_reg <= S_ROOT;
                    end
                end
                S_ROOT:
                begin
                    sqin_reg <= sqin_reg << 2;
                    if (sq_rem_sh >= sq_trial)
                    begin
                        rem_reg  <= sq_rem_sh - sq_trial;
                        root_reg <= {root_reg[sds_pkg::RootW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= sq_rem_sh;
                        root_reg <= {root_reg[sds_pkg::RootW-2:0], 1'b0};
                    end
                    if (step_reg == 6'd1)
                    begin
                        dnum_reg  <= sds_pkg::TenScaled;
                        drem_reg  <= '0;
                        quot_reg  <= '0;
                        step_reg  <= 6'(sds_pkg::DivW);
                        state_reg <= S_DIV;
                    end
                    else
                        step_reg <= step_reg - 1'b1;
                end
                S_DIV:
                begin
                    dnum_reg <= dnum_reg << 1;
                    if (div_sh >= {1'b0, root_reg})
                    begin
                        drem_reg <= div_sh - {1'b0, root_reg};
                        quot_reg <= {quot_reg[sds_pkg::DivW-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= div_sh;
                        quot_reg <= {quot_reg[sds_pkg::DivW-2:0], 1'b0};
                    end
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == 6'd1)
                        state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    if (count_reg < sds_pkg::CountW'(sds_pkg::MaxObjects))
                        count_reg <= count_reg + 1'b1;
                    if (last_reg)
                    begin
                        i_reg     <= sds_pkg::CountW'(1);
                        state_reg <= S_SORT_RD;
                        j_reg     <= '0;
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_SORT_RD:
                begin
                    // j == 0 means fetch entry i as the insertion key
                    if (j_reg == '0 && i_reg >= count_reg)
                    begin
                        e_reg     <= '0;
                        state_reg <= (count_reg == '0) ? S_IDLE : S_EMIT_RD;
                    end
                    else
                        state_reg <= S_SORT_CMP;
                end
                S_SORT_CMP:
                begin
                    if (j_reg == '0)
                    begin
                        skey_reg  <= key_rd_reg;
                        stag_reg  <= tag_rd_reg;
                        j_reg     <= i_reg;
                        state_reg <= S_SORT_RD;
                    end
                    else if (key_rd_reg > skey_reg)
                    begin
                        j_reg     <= j_reg - 1'b1;
                        state_reg <= (j_reg == sds_pkg::CountW'(1)) ? S_SORT_PUT
                                                                    : S_SORT_RD;
                    end
                    else
                        state_reg <= S_SORT_PUT;
                end
                S_SORT_PUT:
                begin
                    i_reg     <= i_reg + 1'b1;
                    j_reg     <= '0;
                    state_reg <= S_SORT_RD;
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        if (e_reg == count_reg)
                        begin
                            out_valid_reg <= 1'b0;
                            count_reg     <= '0;
                            state_reg     <= S_IDLE;
                        end
                        else
                        begin
                            out_valid_reg          <= 1'b1;
                            out_reg.inv_distance   <= key_rd_reg;
                            out_reg.out_kind       <= tag_rd_reg[6];
                            out_reg.out_index      <= tag_rd_reg[5:0];
                            out_reg.last_out       <= (e_reg + 1'b1 == count_reg);
                            e_reg                  <= e_reg + 1'b1;
                            state_reg              <= S_EMIT_RD;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
            if (state_reg != S_EMIT && out_valid_reg && out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // saturated key
    always_comb
    begin
        if (root_reg == '0 || quot_reg > sds_pkg::DivW'(sds_pkg::KeyMax))
            key_reg = sds_pkg::KeyMax;
        else
            key_reg = quot_reg[sds_pkg::KeyW-1:0];
    end

`include "sprite_depth_sort_top_assert.svh"

    `SDS_ASSERT_NOW(a_no_load_busy, clk, rst_n, state_reg != S_IDLE, !in_ch.ready)
    `SDS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= sds_pkg::CountW'(sds_pkg::MaxObjects))
    `SDS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.data))

endmodule

### tb/sds_depth_checker.sv
`timescale 1ns / 1ps

// Watches the load, emit and register channels of the depth sort block,
// predicts every emitted entry and compares it with what the block sends.
module sds_depth_checker (
    input  logic       clk,
    input  logic       rst_n,
    sds_in_if          in_ch,
    sds_out_if         out_ch,
    sds_cfg_if         cfg_ch,
    output int         fail_count,
    output int         pending_count,
    output int         emitted_count
);

    logic [sds_pkg::CoordW-1:0] view_x;
    logic [sds_pkg::CoordW-1:0] view_y;
    logic [sds_pkg::KeyW-1:0]   frame_keys[$];
    logic [sds_pkg::TagW-1:0]   frame_tags[$];
    sds_pkg::out_item_t         sorted_entries[$];

    // floor(sqrt(n)) by the digit-by-digit method
    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // ten over distance, Q0.24, saturated
    function automatic logic [sds_pkg::KeyW-1:0] depth_key(
        logic signed [sds_pkg::CoordW-1:0] px,
        logic signed [sds_pkg::CoordW-1:0] py);
        longint dx;
        longint dy;
        longint unsigned root_dist;
        longint unsigned quot;
        dx   = longint'($signed(view_x)) - longint'(px);
        dy   = longint'($signed(view_y)) - longint'(py);
        root_dist = floor_root(longint'(dx * dx) + longint'(dy * dy));
        if (root_dist == 0)
            return '1;
        quot = (64'd10 << 24) / root_dist;
        return (quot > 64'hFFFFFF) ? 24'hFFFFFF : quot[sds_pkg::KeyW-1:0];
    endfunction

    // stable insertion sort of the frame, then queue the emitted entries
    task automatic close_frame();
        int n;
        int j;
        logic [sds_pkg::KeyW-1:0] k;
        logic [sds_pkg::TagW-1:0] t;
        sds_pkg::out_item_t e;
        n = frame_keys.size();
        for (int i = 1; i < n; i++)
        begin
            k = frame_keys[i];
            t = frame_tags[i];
            j = i;
            while (j > 0 && frame_keys[j-1] > k)
            begin
                frame_keys[j] = frame_keys[j-1];
                frame_tags[j] = frame_tags[j-1];
                j--;
            end
            frame_keys[j] = k;
            frame_tags[j] = t;
        end
        for (int i = 0; i < n; i++)
        begin
            e.inv_distance = frame_keys[i];
            e.out_kind     = frame_tags[i][6];
            e.out_index    = frame_tags[i][5:0];
            e.last_out     = (i == n - 1);
            sorted_entries.push_back(e);
        end
        frame_keys.delete();
        frame_tags.delete();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sds_pkg::out_item_t want;
        sds_pkg::out_item_t got;
        if (!rst_n)
        begin
            view_x        <= '0;
            view_y        <= '0;
            fail_count    <= 0;
            emitted_count <= 0;
            frame_keys.delete();
            frame_tags.delete();
            sorted_entries.delete();
            pending_count = 0;
        end
        else
        begin
            // register writes
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                if (cfg_ch.reg_index == 32'(sds_pkg::RegViewerX))
                    view_x <= cfg_ch.data;
                else if (cfg_ch.reg_index == 32'(sds_pkg::RegViewerY))
                    view_y <= cfg_ch.data;
            end
            // load transfer
            if (in_ch.valid && in_ch.ready)
            begin
                if (frame_keys.size() < sds_pkg::MaxObjects)
                begin
                    frame_keys.push_back(depth_key(in_ch.data.pos_x, in_ch.data.pos_y));
                    frame_tags.push_back({in_ch.data.obj_kind, in_ch.data.obj_index});
                end
                if (in_ch.data.last_load)
                    close_frame();
            end
            // emit transfer
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.data;
                emitted_count <= emitted_count + 1;
                if (sorted_entries.size() == 0)
                begin
                    $error("unexpected entry key=%h kind=%0d index=%0d",
                           got.inv_distance, got.out_kind, got.out_index);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = sorted_entries.pop_front();
                    if (got.inv_distance !== want.inv_distance)
                        $error("inv_distance expected %h actual %h",
                               want.inv_distance, got.inv_distance);
                    if (got.out_kind !== want.out_kind)
                        $error("out_kind expected %0d actual %0d",
                               want.out_kind, got.out_kind);
                    if (got.out_index !== want.out_index)
                        $error("out_index expected %0d actual %0d",
                               want.out_index, got.out_index);
                    if (got.last_out !== want.last_out)
                        $error("last_out expected %0d actual %0d",
                               want.last_out, got.last_out);
                    if (got !== want)
                        fail_count <= fail_count + 1;
                end
            end
            pending_count = sorted_entries.size();
        end
    end
endmodule

### tb/tb_sprite_depth_sort_top.sv
`timescale 1ns / 1ps

module tb_sprite_depth_sort_top;

    localparam int RandomLoads = 360;
    localparam int SettleCycles = 2500;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending_count;
    int   emitted_count;
    int   load_count;
    int   frame_count;
    bit   pause_out;

    sds_in_if  in_ch ();
    sds_out_if out_ch ();
    sds_cfg_if cfg_ch ();

    sprite_depth_sort_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    sds_depth_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_ch         (in_ch),
        .out_ch        (out_ch),
        .cfg_ch        (cfg_ch),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .emitted_count (emitted_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // random stall on the emit side
    initial
    begin
        int g;
        out_ch.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            out_ch.ready <= 1'b1;
            @(posedge clk);
            g = pause_out ? 0 : gap_len();
            if (g > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
        end
    end

    task automatic write_reg(logic [31:0] idx, logic [23:0] value);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.data      <= value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_object(logic [23:0] px, logic [23:0] py, logic kind,
                               logic [5:0] idx, logic last);
        int g;
        g = gap_len();
        if (g > 0)
            repeat (g) @(posedge clk);
        in_ch.valid          <= 1'b1;
        in_ch.data.pos_x     <= px;
        in_ch.data.pos_y     <= py;
        in_ch.data.obj_kind  <= kind;
        in_ch.data.obj_index <= idx;
        in_ch.data.last_load <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        in_ch.valid <= 1'b0;
        load_count++;
        if (last)
            frame_count++;
        @(posedge clk);
    endtask

    // between phases: all entries out, then let the block settle
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // coordinate: mostly near the viewer, sometimes anywhere
    function automatic logic [23:0] rand_coord(logic [23:0] center);
        case ($urandom_range(0, 3))
            0: return 24'($urandom());
            1: return center + 24'($urandom_range(0, 255)) - 24'd128;
            default: return center + 24'($urandom_range(0, 131071)) - 24'd65536;
        endcase
    endfunction

    task automatic random_frame(int n, logic [23:0] vx, logic [23:0] vy);
        logic [23:0] px;
        logic [23:0] py;
        for (int i = 0; i < n; i++)
        begin
            px = rand_coord(vx);
            py = rand_coord(vy);
            // repeat a position now and then to make key ties
            if ($urandom_range(0, 7) == 0)
            begin
                px = vx + 24'h000300;
                py = vy;
            end
            load_object(px, py, 1'($urandom()), 6'($urandom()), i == n - 1);
        end
    endtask

    initial
    begin
        logic [23:0] vx;
        logic [23:0] vy;
        int n;
        rst_n            = 1'b0;
        pause_out        = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data       = '0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.reg_index = '0;
        cfg_ch.data      = '0;
        load_count       = 0;
        frame_count      = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: viewer at origin, extremes, viewer on object, near and tie
        load_object(24'h000000, 24'h000000, 1'b0, 6'd0, 1'b0);
        load_object(24'h7FFFFF, 24'h7FFFFF, 1'b1, 6'd63, 1'b0);
        load_object(24'h800000, 24'h800000, 1'b0, 6'd1, 1'b0);
        load_object(24'h000001, 24'h000000, 1'b1, 6'd2, 1'b0);
        load_object(24'h000A00, 24'h000000, 1'b0, 6'd3, 1'b0);
        load_object(24'h000000, 24'h000A00, 1'b1, 6'd4, 1'b0);
        load_object(24'h7FFFFF, 24'h800000, 1'b0, 6'd5, 1'b1);
        // single-entry frame
        load_object(24'h001000, 24'hFFF000, 1'b1, 6'd42, 1'b1);
        wait_idle();

        // extreme viewer corners, then an unknown register index
        write_reg(32'(sds_pkg::RegViewerX), 24'h7FFFFF);
        write_reg(32'(sds_pkg::RegViewerY), 24'h800000);
        write_reg(32'd2, 24'h123456);
        load_object(24'h800000, 24'h7FFFFF, 1'b0, 6'd10, 1'b0);
        load_object(24'h7FFFFF, 24'h800000, 1'b1, 6'd11, 1'b0);
        load_object(24'h7FFF00, 24'h800000, 1'b0, 6'd12, 1'b1);
        wait_idle();
        write_reg(32'(sds_pkg::RegViewerX), 24'h800000);
        write_reg(32'(sds_pkg::RegViewerY), 24'h7FFFFF);
        load_object(24'h7FFFFF, 24'h800000, 1'b1, 6'd13, 1'b1);
        wait_idle();

        // full store: 64 loads, then overflow loads dropped, last one closes
        for (int i = 0; i < 66; i++)
            load_object(rand_coord(24'h800000), rand_coord(24'h7FFFFF), 1'($urandom()),
                        6'(i), i == 65);
        wait_idle();

        // random frames over several viewer settings, most frames small
        while (load_count < RandomLoads - 30)
        begin
            vx = 24'($urandom());
            vy = 24'($urandom());
            if ($urandom_range(0, 3) == 0)
            begin
                vx = 24'h000000;
                vy = 24'h000000;
            end
            write_reg(32'(sds_pkg::RegViewerX), vx);
            write_reg(32'(sds_pkg::RegViewerY), vy);
            for (int f = 0; f < 3; f++)
            begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 64)
                                                : $urandom_range(1, 8);
                random_frame(n, vx, vy);
            end
            wait_idle();
        end

        // emit side never stalls for one frame
        pause_out = 1'b1;
        random_frame(10, 24'h000000, 24'h000000);
        wait_idle();
        pause_out = 1'b0;

        repeat (SettleCycles) @(posedge clk);
        $display("Covered %0d loads in %0d frames, %0d sorted entries checked",
                 load_count, frame_count, emitted_count);
        $display("including extreme coordinates, full store overflow and key ties");
        if (fail_count == 0 && pending_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // guard against a hung handshake
    initial
    begin
        #20ms;
        $display("DONE: errors detected");
        $finish;
    end
endmodule
